// File: hw/rtl/vr_pkg.sv
// Shared widths and constants for the vector rescale core.
`timescale 1ns / 1ps
package vr_pkg;
  localparam int CoordW   = 32;
  localparam int TgtW     = CoordW - 1;
  localparam int SqW      = 2 * CoordW;
  localparam int ProdW    = CoordW + TgtW;
  localparam int RootW    = CoordW;
  localparam int RemW     = RootW + 2;
  localparam int SqSteps  = RootW;
  localparam int DivSteps = CoordW;
  localparam int Lanes    = 3;

  typedef logic [CoordW-1:0] mag_t;
  typedef logic [ProdW-1:0]  prod_t;
  typedef logic [SqW-1:0]    sq_t;
  typedef logic [RootW-1:0]  root_t;
  typedef logic [RemW-1:0]   rem_t;
endpackage

// File: hw/rtl/vr_if.sv
// Request and result channel interfaces for the vector rescale core.
`timescale 1ns / 1ps
interface vr_in_if import vr_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [CoordW-1:0] coord_x;
  logic signed [CoordW-1:0] coord_y;
  logic signed [CoordW-1:0] coord_z;
  logic [TgtW-1:0]          target_length;
  modport source (output valid, coord_x, coord_y, coord_z, target_length, input ready);
  modport sink   (input valid, coord_x, coord_y, coord_z, target_length, output ready);
endinterface

interface vr_out_if import vr_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [CoordW-1:0] scaled_x;
  logic signed [CoordW-1:0] scaled_y;
  logic signed [CoordW-1:0] scaled_z;
  logic [CoordW-1:0]        input_length;
  logic                     zero_vector;
  logic                     saturated;
  modport source (output valid, scaled_x, scaled_y, scaled_z, input_length, zero_vector,
                  saturated, input ready);
  modport sink   (input valid, scaled_x, scaled_y, scaled_z, input_length, zero_vector,
                  saturated, output ready);
endinterface

// File: hw/rtl/vector_rescale_core.sv
// Pipelined 3-D vector rescale: length by square root, components scaled by target / length.
//  channel  | dir | handshake    | payload
//  in_ch    | in  | valid/ready  | coord_x/y/z, target_length
//  out_ch   | out | valid/ready  | scaled_x/y/z, input_length, zero_vector, saturated
// One request per cycle while out_ch is not stalled; 32 root stages and 32 divider stages.
// The root and divider units retire one bit per stage, which sets the depth.
// Reset clears all stage valid bits. A stalled result holds the whole pipeline;
// nothing is dropped or repeated.
`timescale 1ns / 1ps
module vector_rescale_core import vr_pkg::*; (
  input logic  clk,
  input logic  rst_n,
  vr_in_if.sink    in_ch,
  vr_out_if.source out_ch
);
  logic en;

  // stage 1: magnitudes
  logic              v1_r;
  mag_t              mag1_r [Lanes];
  logic [Lanes-1:0]  neg1_r;
  logic [TgtW-1:0]   tgt1_r;
  mag_t              cin    [Lanes];

  // stage 2: products
  logic              v2_r;
  sq_t               sq2_r  [Lanes];
  prod_t             prod2_r[Lanes];
  logic [Lanes-1:0]  neg2_r;

  // root stages
  logic              sv_r    [SqSteps+1];
  sq_t               rad_r   [SqSteps+1];
  rem_t              srem_r  [SqSteps+1];
  root_t             root_r  [SqSteps+1];
  prod_t             sprod_r [SqSteps+1][Lanes];
  logic [Lanes-1:0]  sneg_r  [SqSteps+1];

  // rounding stage
  logic              vr_r;
  root_t             len_r;
  prod_t             rprod_r [Lanes];
  logic [Lanes-1:0]  rneg_r;
  logic [RootW:0]    len_nxt;

  // divider stages
  logic              dv_r   [DivSteps+1];
  root_t             dlen_r [DivSteps+1];
  mag_t              dnum_r [DivSteps+1][Lanes];
  root_t             drem_r [DivSteps+1][Lanes];
  logic [Lanes-1:0]  dovf_r [DivSteps+1];
  logic [Lanes-1:0]  dneg_r [DivSteps+1];

  // output register
  logic              ov_r;
  mag_t              oval_r [Lanes];
  root_t             olen_r;
  logic              ozero_r;
  logic              osat_r;

  assign en          = ~ov_r | out_ch.ready;
  assign in_ch.ready = en;

  assign cin[0] = mag_t'(in_ch.coord_x);
  assign cin[1] = mag_t'(in_ch.coord_y);
  assign cin[2] = mag_t'(in_ch.coord_z);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      vr_r  <= 1'b0;
      ov_r  <= 1'b0;
    end else if (en) begin
      v1_r  <= in_ch.valid;
      v2_r  <= v1_r;
      vr_r  <= sv_r[SqSteps];
      ov_r  <= dv_r[DivSteps];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tgt1_r <= in_ch.target_length;
      for (int k = 0; k < Lanes; k++) begin
        neg1_r[k]  <= cin[k][CoordW-1];
        mag1_r[k]  <= cin[k][CoordW-1] ? (~cin[k] + mag_t'(1)) : cin[k];
        sq2_r[k]   <= mag1_r[k] * mag1_r[k];
        prod2_r[k] <= mag1_r[k] * tgt1_r;
      end
      neg2_r <= neg1_r;
    end
  end

  // sum of squares enters the root pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sv_r[0] <= 1'b0;
    end else if (en) begin
      sv_r[0] <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad_r[0]  <= sq2_r[0] + sq2_r[1] + sq2_r[2];
      srem_r[0] <= '0;
      root_r[0] <= '0;
      sprod_r[0] <= prod2_r;
      sneg_r[0] <= neg2_r;
    end
  end

  for (genvar i = 0; i < SqSteps; i++) begin : g_sqrt
    logic [RemW+1:0] cur;
    logic [RemW+1:0] trial;
    logic            take;
    assign cur   = {srem_r[i], rad_r[i][SqW-1 -: 2]};
    assign trial = {2'b00, root_r[i], 2'b01};
    assign take  = cur >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sv_r[i+1] <= 1'b0;
      end else if (en) begin
        sv_r[i+1] <= sv_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad_r[i+1]   <= {rad_r[i][SqW-3:0], 2'b00};
        srem_r[i+1]  <= take ? rem_t'(cur - trial) : rem_t'(cur);
        root_r[i+1]  <= {root_r[i][RootW-2:0], take};
        sprod_r[i+1] <= sprod_r[i];
        sneg_r[i+1]  <= sneg_r[i];
      end
    end
  end

  // round to nearest and clamp
  assign len_nxt = {1'b0, root_r[SqSteps]} +
                   (RootW+1)'(srem_r[SqSteps] > rem_t'(root_r[SqSteps]));

  always_ff @(posedge clk) begin
    if (en) begin
      len_r   <= len_nxt[RootW] ? '1 : len_nxt[RootW-1:0];
      rprod_r <= sprod_r[SqSteps];
      rneg_r  <= sneg_r[SqSteps];
    end
  end

  // divider setup: overflow check and first partial remainder
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r[0] <= 1'b0;
    end else if (en) begin
      dv_r[0] <= vr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dlen_r[0] <= len_r;
      dneg_r[0] <= rneg_r;
      for (int k = 0; k < Lanes; k++) begin
        dovf_r[0][k] <= {1'b0, rprod_r[k]} >= {len_r, mag_t'(0)};
        drem_r[0][k] <= root_t'(rprod_r[k][ProdW-1:CoordW]);
        dnum_r[0][k] <= rprod_r[k][CoordW-1:0];
      end
    end
  end

  for (genvar i = 0; i < DivSteps; i++) begin : g_div
    logic [RootW:0] dcur [Lanes];
    logic           dtake[Lanes];
    for (genvar k = 0; k < Lanes; k++) begin : g_lane
      assign dcur[k]  = {drem_r[i][k], dnum_r[i][k][CoordW-1]};
      assign dtake[k] = dcur[k] >= {1'b0, dlen_r[i]};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[i+1] <= 1'b0;
      end else if (en) begin
        dv_r[i+1] <= dv_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dlen_r[i+1] <= dlen_r[i];
        dovf_r[i+1] <= dovf_r[i];
        dneg_r[i+1] <= dneg_r[i];
        for (int k = 0; k < Lanes; k++) begin
          drem_r[i+1][k] <= dtake[k] ? root_t'(dcur[k] - {1'b0, dlen_r[i]})
                                     : root_t'(dcur[k]);
          dnum_r[i+1][k] <= {dnum_r[i][k][CoordW-2:0], dtake[k]};
        end
      end
    end
  end

  // saturate, restore sign, handle zero length
  mag_t             lim  [Lanes];
  logic [Lanes-1:0] clip;
  mag_t             mres [Lanes];
  logic             zlen;

  assign zlen = dlen_r[DivSteps] == '0;

  always_comb begin
    for (int k = 0; k < Lanes; k++) begin
      lim[k]  = dneg_r[DivSteps][k] ? {1'b1, {(CoordW-1){1'b0}}} : {1'b0, {(CoordW-1){1'b1}}};
      clip[k] = dovf_r[DivSteps][k] || (dnum_r[DivSteps][k] > lim[k]);
      mres[k] = clip[k] ? lim[k] : dnum_r[DivSteps][k];
      mres[k] = dneg_r[DivSteps][k] ? (~mres[k] + mag_t'(1)) : mres[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      olen_r  <= dlen_r[DivSteps];
      ozero_r <= zlen;
      osat_r  <= ~zlen & (|clip);
      for (int k = 0; k < Lanes; k++) begin
        oval_r[k] <= zlen ? mag_t'(0) : mres[k];
      end
    end
  end

  assign out_ch.valid        = ov_r;
  assign out_ch.scaled_x     = oval_r[0];
  assign out_ch.scaled_y     = oval_r[1];
  assign out_ch.scaled_z     = oval_r[2];
  assign out_ch.input_length = olen_r;
  assign out_ch.zero_vector  = ozero_r;
  assign out_ch.saturated    = osat_r;

`ifndef NO_ASSERTIONS
  a_zero_clean: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && ozero_r |-> !osat_r && olen_r == '0)
    else $error("zero vector result carries length or saturation");
  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> v1_r)
    else $error("accepted request lost at first stage");
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(dv_r[DivSteps]) && ov_r)
    else $error("pipeline advanced during stall");
`endif
endmodule
